// ----- rtl/lzss_tsd_pkg.sv -----
// Shared types and constants for the LZSS token stream decompressor.
// No dependencies; imported by lzss_token_stream_decompressor.
`default_nettype none

package lzss_tsd_pkg;

    // Parse position within the compressed stream.
    typedef enum logic [2:0] {
        PH_SIZE_HI = 3'd0,
        PH_SIZE_LO = 3'd1,
        PH_FLAG    = 3'd2,
        PH_TOKEN   = 3'd3,
        PH_REF_LO  = 3'd4
    } phase_t;

    localparam logic [7:0]  REF_FLAG_MASK = 8'h80;  // flag bit set: back reference
    localparam logic [3:0]  LEN_MASK      = 4'h0F;
    localparam logic [3:0]  FLAGS_PER_GRP = 4'd8;
    localparam logic [4:0]  MIN_MATCH     = 5'd3;   // added to length and distance
    localparam int unsigned DIST_W        = 13;     // 12-bit field plus offset

endpackage : lzss_tsd_pkg

`default_nettype wire

// ----- rtl/lzss_token_stream_decompressor.sv -----
// LZSS token stream decompressor: header/flag/token parser, copy engine and history window.
// Depends on lzss_tsd_pkg.
`default_nettype none

// Takes compressed words one per handshake and emits decoded words on an output register
// with valid/ready. After reset the history window is swept to zero, one entry per cycle,
// and the input stays not-ready until the sweep is done. Header, flag and reference words
// are taken whenever the copy engine is idle; a literal also needs a free output slot. The
// second word of a back reference (count = 1..18 decoded words) loads the copy counters and
// holds the input until the copy is done: each read of the single window memory is
// registered, then one decoded word per cycle while the output is not stalled, with one
// window read and one write per cycle. A stalled output holds the copy engine in place.
module lzss_token_stream_decompressor
    import lzss_tsd_pkg::*;
#(
    parameter int unsigned WINDOW_DEPTH = 8192
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            run_last,
    output logic            stream_done,
    output logic            overrun_error
);

    localparam int unsigned AW = $clog2(WINDOW_DEPTH);
    localparam logic [AW-1:0] DEPTH_M1 = AW'(WINDOW_DEPTH - 1);
    localparam logic [AW:0]   DEPTH_X  = (AW+1)'(WINDOW_DEPTH);

    // history window
    logic [7:0]    window_mem [WINDOW_DEPTH];
    logic [7:0]    rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;

    // control and datapath registers
    phase_t        phase_reg, phase_next;
    logic [15:0]   rem_reg, rem_next;
    logic [7:0]    flag_reg, flag_next;
    logic [3:0]    flags_left_reg, flags_left_next;
    logic [7:0]    hold_reg;
    logic [AW-1:0] wp_reg, wp_next;
    logic          clr_reg;
    logic [AW-1:0] clr_ptr_reg;
    logic [AW-1:0] src_reg, src_next;
    logic [4:0]    left_reg, left_next;
    logic          err_reg, err_next;
    logic          rd_pend_reg, rd_pend_next;
    logic          pend_last_reg, pend_last_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic          run_last_reg, run_last_next;
    logic          done_reg, done_next;
    logic          oerr_reg, oerr_next;

    logic          in_acc;
    logic          slot_free;
    logic          engine_idle;
    logic          lit_token;
    logic          emit_lit;
    logic          move;
    logic [15:0]   rem_lit;
    logic [4:0]    ref_len;
    logic [4:0]    ref_cnt;
    logic          ref_err;
    logic [DIST_W-1:0] ref_dist;
    logic [AW:0]   src_diff;
    logic [AW-1:0] ref_src;
    logic [15:0]   rem_ref;
    logic [3:0]    flags_dec;
    logic [15:0]   rem_after;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == DEPTH_M1) ? '0 : p + AW'(1);
    endfunction

    assign slot_free   = !out_valid_reg || out_ready;
    assign engine_idle = !clr_reg && (left_reg == 5'd0) && !rd_pend_reg;
    assign lit_token   = (phase_reg == PH_TOKEN) && ((flag_reg & REF_FLAG_MASK) == 8'h00);
    assign in_ready    = engine_idle && (!lit_token || slot_free);
    assign in_acc      = in_valid && in_ready;
    assign emit_lit    = in_acc && lit_token;
    assign move        = rd_pend_reg && slot_free;
    assign rd_en       = (left_reg != 5'd0) && (!rd_pend_reg || move);

    // reference decode
    assign ref_len  = {1'b0, in_byte[3:0] & LEN_MASK} + MIN_MATCH;
    assign ref_err  = {11'd0, ref_len} > rem_reg;
    assign ref_cnt  = ref_err ? rem_reg[4:0] : ref_len;
    assign ref_dist = {hold_reg, in_byte[7:4]} + DIST_W'(MIN_MATCH);
    assign src_diff = {1'b0, wp_reg} - (AW+1)'(ref_dist);
    assign ref_src  = src_diff[AW] ? AW'(src_diff + DEPTH_X) : src_diff[AW-1:0];
    assign rem_ref  = rem_reg - {11'd0, ref_cnt};
    assign rem_lit  = rem_reg - 16'd1;
    assign flags_dec = flags_left_reg - 4'd1;
    assign rem_after = (phase_reg == PH_REF_LO) ? rem_ref : rem_lit;

    // parse phase
    always_comb
    begin
        phase_next = phase_reg;
        if (in_acc)
        begin
            unique case (phase_reg) inside
                PH_SIZE_HI: phase_next = PH_SIZE_LO;
                PH_SIZE_LO: phase_next = ({rem_reg[15:8], in_byte} == 16'd0) ? PH_SIZE_HI
                                                                              : PH_FLAG;
                PH_FLAG:    phase_next = PH_TOKEN;
                PH_TOKEN,
                PH_REF_LO:
                begin
                    if (phase_reg == PH_TOKEN && !lit_token)
                        phase_next = PH_REF_LO;
                    else if (rem_after == 16'd0)
                        phase_next = PH_SIZE_HI;
                    else if (flags_dec == 4'd0)
                        phase_next = PH_FLAG;
                    else
                        phase_next = PH_TOKEN;
                end
                default:    phase_next = PH_SIZE_HI;
            endcase
        end
    end

    // datapath and output register
    always_comb
    begin
        rem_next        = rem_reg;
        flag_next       = flag_reg;
        flags_left_next = flags_left_reg;
        wp_next         = wp_reg;
        src_next        = src_reg;
        left_next       = left_reg;
        err_next        = err_reg;
        rd_pend_next    = rd_pend_reg;
        pend_last_next  = pend_last_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_byte_next   = out_byte_reg;
        run_last_next   = run_last_reg;
        done_next       = done_reg;
        oerr_next       = oerr_reg;

        if (in_acc)
        begin
            case (phase_reg)
                PH_SIZE_HI: rem_next = {in_byte, 8'd0};
                PH_SIZE_LO: rem_next = {rem_reg[15:8], in_byte};
                PH_FLAG:
                begin
                    flag_next       = in_byte;
                    flags_left_next = FLAGS_PER_GRP;
                end
                PH_TOKEN:
                begin
                    if (lit_token)
                    begin
                        rem_next        = rem_lit;
                        flag_next       = {flag_reg[6:0], 1'b0};
                        flags_left_next = flags_dec;
                    end
                end
                PH_REF_LO:
                begin
                    rem_next        = rem_ref;
                    flag_next       = {flag_reg[6:0], 1'b0};
                    flags_left_next = flags_dec;
                    src_next        = ref_src;
                    left_next       = ref_cnt;
                    err_next        = ref_err;
                end
                default: ;
            endcase
        end

        // issue one window read per cycle while the output is not stalled
        if (rd_en)
        begin
            src_next       = ptr_inc(src_reg);
            left_next      = left_reg - 5'd1;
            pend_last_next = (left_reg == 5'd1);
            rd_pend_next   = 1'b1;
        end
        else if (move)
        begin
            rd_pend_next = 1'b0;
        end

        if (emit_lit)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = in_byte;
            run_last_next  = 1'b1;
            done_next      = (rem_lit == 16'd0);
            oerr_next      = 1'b0;
            wp_next        = ptr_inc(wp_reg);
        end
        else if (move)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = rd_data_reg;
            run_last_next  = pend_last_reg;
            done_next      = pend_last_reg && (rem_reg == 16'd0);
            oerr_next      = err_reg;
            wp_next        = ptr_inc(wp_reg);
        end
    end

    // window write port: clear sweep, literal, or copied word
    always_comb
    begin
        mem_we  = 1'b0;
        wr_addr = wp_reg;
        wr_data = in_byte;
        if (clr_reg)
        begin
            mem_we  = 1'b1;
            wr_addr = clr_ptr_reg;
            wr_data = 8'd0;
        end
        else if (emit_lit)
        begin
            mem_we = 1'b1;
        end
        else if (move)
        begin
            mem_we  = 1'b1;
            wr_data = rd_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            window_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= window_mem[src_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SIZE_HI;
            rem_reg        <= '0;
            flag_reg       <= '0;
            flags_left_reg <= '0;
            hold_reg       <= '0;
            wp_reg         <= '0;
            clr_reg        <= 1'b1;
            clr_ptr_reg    <= '0;
            left_reg       <= '0;
            rd_pend_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            rem_reg        <= rem_next;
            flag_reg       <= flag_next;
            flags_left_reg <= flags_left_next;
            if (in_acc && phase_reg == PH_TOKEN)
                hold_reg <= in_byte;
            wp_reg         <= wp_next;
            if (clr_reg)
            begin
                clr_ptr_reg <= ptr_inc(clr_ptr_reg);
                if (clr_ptr_reg == DEPTH_M1)
                    clr_reg <= 1'b0;
            end
            left_reg       <= left_next;
            rd_pend_reg    <= rd_pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg       <= src_next;
        err_reg       <= err_next;
        pend_last_reg <= pend_last_next;
        out_byte_reg  <= out_byte_next;
        run_last_reg  <= run_last_next;
        done_reg      <= done_next;
        oerr_reg      <= oerr_next;
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign run_last      = run_last_reg;
    assign stream_done   = done_reg;
    assign overrun_error = oerr_reg;

    // a copy source always trails the write position by at least two entries
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && mem_we) |-> (src_reg != wr_addr))
        else $error("window read and write hit the same entry");

    a_no_input_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr_reg |-> !in_ready)
        else $error("input accepted during window clear");

    a_pend_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_pend_reg && !slot_free) |=> (rd_pend_reg && $stable(rd_data_reg)))
        else $error("pending window word lost under output stall");

    a_copy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && phase_reg == PH_REF_LO) |=> (!in_ready && left_reg != 5'd0))
        else $error("copy not started after reference");

endmodule : lzss_token_stream_decompressor

`default_nettype wire

// ----- bench/lzss_token_stream_decompressor_tb.sv -----
// Self-checking bench for lzss_token_stream_decompressor: a queue-fed word driver, an output
// monitor, and an in-bench LZSS decoder that predicts every decoded word.
// Depends on lzss_tsd_pkg and the decompressor RTL.
`default_nettype none

module lzss_token_stream_decompressor_tb;
    import lzss_tsd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN_DEPTH = 8192;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int MAX_PRINTED = 50;

    // Zero size, literal extremes, reference before data, truncated copy at
    // maximum distance and length, overlapping maximum-length copy ending the stream.
    localparam logic [7:0] DIRECTED_BYTES [20] = '{
        8'h00, 8'h00,
        8'h00, 8'h05, 8'h40, 8'hFF, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h04, 8'h80, 8'hFF, 8'hFF,
        8'h00, 8'h13, 8'h40, 8'hA5, 8'h00, 8'h0F
    };

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       done;
        logic       overrun;
    } dec_word_t;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_done;
    logic       overrun_error;

    logic [7:0] compressed_bytes [$];
    dec_word_t  pending_decoded [$];

    // decoder state mirrored in the bench
    logic [7:0]  hist_win [WIN_DEPTH];
    int          wr_ptr;
    logic [15:0] left_cnt;
    phase_t      parse_ph;
    logic [7:0]  flag_reg;
    logic [3:0]  flags_left;
    logic [7:0]  ref_hi;

    int   err_count;
    int   accepted_cnt;
    int   send_gap;
    int   rx_gap;
    int   hold_left;
    logic hold_done;
    logic tail_phase;
    int   idle_pct;
    int   cycle_cnt;

    lzss_token_stream_decompressor #(
        .WINDOW_DEPTH (WIN_DEPTH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .run_last      (run_last),
        .stream_done   (stream_done),
        .overrun_error (overrun_error)
    );

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= MAX_PRINTED)
            $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task automatic emit_word(input logic [7:0] v, input logic last, input logic err);
        dec_word_t w;
        hist_win[wr_ptr] = v;
        wr_ptr = (wr_ptr + 1) % WIN_DEPTH;
        w.data     = v;
        w.run_last = last;
        w.done     = last && (left_cnt == 16'd0);
        w.overrun  = err;
        pending_decoded.push_back(w);
    endtask

    task automatic next_token();
        flag_reg   = flag_reg << 1;
        flags_left = flags_left - 4'd1;
        if (left_cnt == 16'd0)
            parse_ph = PH_SIZE_HI;
        else if (flags_left == 4'd0)
            parse_ph = PH_FLAG;
        else
            parse_ph = PH_TOKEN;
    endtask

    // Advance the mirrored decoder by one compressed word and queue its output words.
    task automatic lzss_decode_byte(input logic [7:0] b);
        int ref_dist;
        int count;
        int src;
        logic err;
        logic [7:0] v;
        case (parse_ph)
            PH_SIZE_HI:
            begin
                left_cnt = {b, 8'h00};
                parse_ph = PH_SIZE_LO;
            end
            PH_SIZE_LO:
            begin
                left_cnt[7:0] = b;
                parse_ph = (left_cnt == 16'd0) ? PH_SIZE_HI : PH_FLAG;
            end
            PH_FLAG:
            begin
                flag_reg   = b;
                flags_left = FLAGS_PER_GRP;
                parse_ph   = PH_TOKEN;
            end
            PH_TOKEN:
            begin
                if ((flag_reg & REF_FLAG_MASK) != 8'h00)
                begin
                    ref_hi   = b;
                    parse_ph = PH_REF_LO;
                end
                else
                begin
                    left_cnt = left_cnt - 16'd1;
                    emit_word(b, 1'b1, 1'b0);
                    next_token();
                end
            end
            PH_REF_LO:
            begin
                ref_dist = int'({ref_hi, b[7:4]}) + int'(MIN_MATCH);
                count    = int'(b & LEN_MASK) + int'(MIN_MATCH);
                err      = 1'b0;
                if (count > int'(left_cnt))
                begin
                    count = int'(left_cnt);
                    err   = 1'b1;
                end
                src = (wr_ptr + WIN_DEPTH - (ref_dist % WIN_DEPTH)) % WIN_DEPTH;
                for (int i = 0; i < count; i++)
                begin
                    v = hist_win[src];
                    src = (src + 1) % WIN_DEPTH;
                    left_cnt = left_cnt - 16'd1;
                    emit_word(v, i + 1 == count, err);
                end
                next_token();
            end
            default: parse_ph = PH_SIZE_HI;
        endcase
    endtask

    // Build one stream with random content; its last reference may overrun the size.
    task automatic gen_stream(input logic [15:0] size);
        int rem;
        int cnt;
        logic [7:0] flag;
        logic [7:0] hi;
        logic [7:0] lo;
        rem = int'(size);
        compressed_bytes.push_back(size[15:8]);
        compressed_bytes.push_back(size[7:0]);
        while (rem > 0)
        begin
            for (int k = 0; k < 8; k++)
                flag[k] = ($urandom_range(0, 99) < 60);
            compressed_bytes.push_back(flag);
            for (int k = 7; k >= 0 && rem > 0; k--)
            begin
                if (flag[k])
                begin
                    case ($urandom_range(0, 3)) inside
                        0, 1:    hi = 8'h00;
                        2:       hi = 8'($urandom_range(0, 15));
                        default: hi = 8'($urandom_range(0, 255));
                    endcase
                    lo = 8'($urandom_range(0, 255));
                    if ($urandom_range(0, 9) < 7)
                        lo[3:0] = 4'($urandom_range(8, 15));
                    compressed_bytes.push_back(hi);
                    compressed_bytes.push_back(lo);
                    cnt = int'(lo & LEN_MASK) + int'(MIN_MATCH);
                    if (cnt > rem)
                        cnt = rem;
                    rem -= cnt;
                end
                else
                begin
                    compressed_bytes.push_back(8'($urandom_range(0, 255)));
                    rem--;
                end
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #15ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Re-pick the idle rate now and then so that quiet stretches occur too.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_cnt <= 0;
            idle_pct  <= 0;
        end
        else
        begin
            cycle_cnt <= cycle_cnt + 1;
            if (cycle_cnt % 64 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       idle_pct <= 0;
                    1:       idle_pct <= 10;
                    default: idle_pct <= 30;
                endcase
            end
        end
    end

    // Driver: offer compressed words from the queue, predict on each accepted word.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            in_byte      <= 8'h00;
            send_gap     <= 0;
            accepted_cnt <= 0;
            tail_phase   <= 1'b0;
        end
        else
        begin
            tail_phase <= (compressed_bytes.size() < 100);
            if (!in_valid || in_ready)
            begin
                if (in_valid)
                begin
                    lzss_decode_byte(in_byte);
                    accepted_cnt <= accepted_cnt + 1;
                end
                if (send_gap != 0)
                begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (compressed_bytes.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (!tail_phase && $urandom_range(0, 99) < idle_pct)
                begin
                    in_valid <= 1'b0;
                    send_gap <= $urandom_range(0, 3);
                end
                else
                begin
                    in_valid <= 1'b1;
                    in_byte  <= compressed_bytes.pop_front();
                end
            end
        end
    end

    // One long receiver hold so the block backs up into its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && accepted_cnt >= 60)
        begin
            hold_left <= LONG_HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Monitor: check each accepted output word against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        dec_word_t got;
        dec_word_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_gap    <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = {out_byte, run_last, stream_done, overrun_error};
                if (pending_decoded.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected word data=%02h last=%b done=%b err=%b",
                        got.data, got.run_last, got.done, got.overrun));
                end
                else
                begin
                    want = pending_decoded.pop_front();
                    if (got !== want)
                        report_mismatch($sformatf(
                            "got data=%02h last=%b done=%b err=%b, exp %02h %b %b %b",
                            got.data, got.run_last, got.done, got.overrun,
                            want.data, want.run_last, want.done, want.overrun));
                end
            end
            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
            end
            else if (rx_gap != 0)
            begin
                out_ready <= 1'b0;
                rx_gap    <= rx_gap - 1;
            end
            else if (!tail_phase && $urandom_range(0, 99) < idle_pct)
            begin
                out_ready <= 1'b0;
                rx_gap    <= $urandom_range(0, 3);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int sel;
        logic [15:0] size;
        err_count     = 0;
        wr_ptr        = 0;
        left_cnt      = 16'd0;
        parse_ph      = PH_SIZE_HI;
        flag_reg      = 8'h00;
        flags_left    = 4'd0;
        ref_hi        = 8'h00;
        foreach (hist_win[i])
            hist_win[i] = 8'h00;

        foreach (DIRECTED_BYTES[i])
            compressed_bytes.push_back(DIRECTED_BYTES[i]);
        while (compressed_bytes.size() < 230)
        begin
            sel = $urandom_range(0, 9);
            if (sel == 0)
                size = 16'd0;
            else if (sel < 3)
                size = 16'($urandom_range(49, 400));
            else
                size = 16'($urandom_range(1, 48));
            gen_stream(size);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (compressed_bytes.size() != 0 || in_valid)
            @(posedge clk);
        while (pending_decoded.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_decoded.size() != 0)
            report_mismatch($sformatf("%0d predicted words never arrived",
                pending_decoded.size()));

        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule : lzss_token_stream_decompressor_tb

`default_nettype wire
